>>> rtl/nonlinear_feedback_filter_assert.svh
// assertion macros shared by the nonlinear feedback filter rtl
`ifndef NONLINEAR_FEEDBACK_FILTER_ASSERT_SVH
`define NONLINEAR_FEEDBACK_FILTER_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define NFF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define NFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/nff_pkg.sv
`timescale 1ns / 1ps
// constants, microcode types and the tanh table of the nonlinear feedback filter
package nff_pkg;

   // storage and field sizes
   localparam int RING_DEPTH      = 1024;
   localparam int RING_AW         = $clog2(RING_DEPTH);
   localparam int FILL_W          = RING_AW + 1;
   localparam int TANH_TABLE_SIZE = 256;
   localparam int TANH_W          = $clog2(TANH_TABLE_SIZE);
   localparam int SAMPLE_W        = 16;
   localparam int LEN_W           = 11;
   localparam int TAP_W           = (LEN_W > RING_AW + 1) ? LEN_W : RING_AW + 1;
   localparam int CSR_IDX_W       = 3;

   // fixed point formats
   localparam int COEF_FRAC = 12;
   localparam int ACC_FRAC  = 27;
   localparam int ACC_W     = 35;
   localparam int ACCS_W    = 32;
   localparam int INTERP_W  = 16;
   localparam int SQ_W      = 17;
   localparam int MUL_A_W   = 32;
   localparam int MUL_B_W   = 18;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;

   localparam logic [MUL_B_W-1:0]         INV_MAXAMP_Q16  = 18'd33867;
   localparam logic [MUL_B_W-1:0]         HALF_MAXAMP_Q16 = 18'd63410;
   localparam logic signed [SAMPLE_W-1:0] HALF_MAXAMP_Q14 = 16'sd15853;
   localparam logic [SAMPLE_W-1:0]        TANH_MAX        = 16'd32767;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_A    = 3'd0,
      REG_COEF_B    = 3'd1,
      REG_COEF_D    = 3'd2,
      REG_OFFSET_C  = 3'd3,
      REG_DELAY_LEN = 3'd4
   } reg_index_type;

   // microcode
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] STEP_SQUARE = 4'd1;
   localparam logic [PC_W-1:0] STEP_MUL_A  = 4'd2;
   localparam logic [PC_W-1:0] STEP_MUL_B  = 4'd3;
   localparam logic [PC_W-1:0] STEP_MUL_D  = 4'd4;
   localparam logic [PC_W-1:0] STEP_MUL_X  = 4'd5;
   localparam logic [PC_W-1:0] STEP_SUM    = 4'd6;
   localparam logic [PC_W-1:0] STEP_SCALE  = 4'd7;
   localparam logic [PC_W-1:0] STEP_LOOKUP = 4'd8;
   localparam logic [PC_W-1:0] STEP_INTERP = 4'd9;
   localparam logic [PC_W-1:0] STEP_COMMIT = 4'd10;

   typedef enum logic [1:0] {RD_NONE, RD_YL, RD_Y1, RD_Y2} rd_sel_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_YL_YL, MUL_A_Y1, MUL_B_Y2, MUL_D_SQ, MUL_X_K, MUL_ACC_K, MUL_D_FRAC
   } mul_sel_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_INIT, ACC_ADD, ACC_FINAL} acc_op_type;

   typedef enum logic [2:0] {AUX_NONE, AUX_SQ, AUX_MAG, AUX_TAB, AUX_COMMIT} aux_type;

   typedef enum logic [1:0] {COND_ALWAYS, COND_REQ, COND_RSP} cond_type;

   typedef struct packed {
      rd_sel_type       rd;
      mul_sel_type      mul;
      acc_op_type       acc;
      aux_type          aux;
      cond_type         cond;
      logic [PC_W-1:0]  next_step;
   } ucode_type;

   // tanh(4*i/TANH_TABLE_SIZE) in Q1.15 from an integer exponential series
   typedef logic [SAMPLE_W-1:0] tanh_tab_type [TANH_TABLE_SIZE+1];

   // unsigned 64-bit long division by shift and subtract, for table building
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic tanh_tab_type build_tanh_table();
      tanh_tab_type tab;
      logic [63:0]  one;
      logic [63:0]  y16;
      logic [63:0]  e;
      logic [63:0]  term;
      logic [63:0]  t;
      logic         done;
      one = 64'd1 << 32;
      for (int i = 0; i <= TANH_TABLE_SIZE; i++) begin
         y16  = (64'(8 * i) << 16) >> TANH_W;
         e    = one;
         term = one;
         done = 1'b0;
         for (int k = 1; k < 100; k++) begin
            if (!done) begin
               term = udiv64((term * y16) >> 16, 64'(k));
               if (term == 64'd0) begin
                  done = 1'b1;
               end else begin
                  e = e + term;
               end
            end
         end
         t = udiv64((e - one) * 64'd32768 + ((e + one) >> 1), e + one);
         if (t > 64'd32767) begin
            t = 64'd32767;
         end
         tab[i] = t[SAMPLE_W-1:0];
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TABLE = build_tanh_table();

endpackage

>>> rtl/nonlinear_feedback_filter.sv
`timescale 1ns / 1ps
// nonlinear feedback filter: microcoded datapath with tanh delay ring
//
// usage
//  - req channel (req_tvalid/req_tready/req_tdata) takes one Q1.15 audio sample per
//    transaction; rsp channel returns one Q2.14 sample per input transaction, in order
//  - csr channel writes coef_a, coef_b, coef_d, offset_c (index 0..3) and delay_len
//    (index 4); csr_ready is always high, unknown indexes are dropped; write only
//    while no sample is in flight
//  - an 11-step microprogram drives one shared 32x18 multiplier and one read port
//    of the 1024-entry history ring; a sample runs from acceptance through the
//    steps to the ring write at the commit step, and the block takes no new sample
//    until the sequencer is back at the idle step
//  - rsp_tvalid rises with the ring write at the commit step; the result sits in an
//    output register, and req_tready comes back in the same cycle, so the next
//    sample runs while the receiver still holds off
//  - if the output register is still full when the next result is ready, the
//    sequencer waits at its last step until rsp_tready frees it
//  - synchronous reset clears the step counter, output valid, write pointer,
//    registers (delay_len back to 1) and the ring fill count; ring entries not
//    written since reset read as zero, so no clearing pass is needed
`include "nonlinear_feedback_filter_assert.svh"

module nonlinear_feedback_filter
   import nff_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input samples
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   // output samples
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,   // [15:0] sample_out
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_data
);

   // saturation limits and rounding constants
   localparam logic signed [ACC_W-1:0]  ACC_POS_LIM = {{(ACC_W-ACCS_W+1){1'b0}},
                                                       {(ACCS_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_NEG_LIM = {{(ACC_W-ACCS_W+1){1'b1}},
                                                       {(ACCS_W-1){1'b0}}};
   localparam logic signed [ACCS_W-1:0] ACC_TWO     = ACCS_W'(1) << (ACC_FRAC + 1);
   localparam logic signed [ACCS_W-1:0] ACC_MTWO    = -ACC_TWO;
   localparam logic signed [PROD_W-1:0] OUT_RND     = PROD_W'(1) << (ACC_FRAC + 1);

   // configuration registers
   logic signed [SAMPLE_W-1:0] coef_a_ff;
   logic signed [SAMPLE_W-1:0] coef_b_ff;
   logic signed [SAMPLE_W-1:0] coef_d_ff;
   logic signed [SAMPLE_W-1:0] offset_c_ff;
   logic [TAP_W-1:0]           tap_len_ff;
   logic [TAP_W-1:0]           tap_len_in;

   // sequencer
   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_type       uc;
   logic            go;
   logic            out_free;
   logic            commit_go;

   // ring and its read side
   logic [SAMPLE_W-1:0]        ring_mem [RING_DEPTH];
   logic [RING_AW-1:0]         wp_ff;
   logic [RING_AW-1:0]         wp_in;
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic [RING_AW-1:0]         rd_addr;
   logic                       rd_addr_ok;
   logic [RING_AW-1:0]         addr_yl;
   logic [SAMPLE_W-1:0]        mem_q_ff;
   logic                       rd_ok_ff;
   logic signed [SAMPLE_W-1:0] rd_val;

   // datapath
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_sum;
   logic signed [ACCS_W-1:0]   accs_ff;
   logic [ACCS_W-1:0]          mag;
   logic [TANH_W-1:0]          idx_ff;
   logic [INTERP_W-1:0]        frac_ff;
   logic                       neg_ff;
   logic                       big_ff;
   logic [TANH_W:0]            idx0;
   logic [TANH_W:0]            idx1;
   logic [SAMPLE_W-1:0]        t0;
   logic [SAMPLE_W-1:0]        t1;
   logic [SAMPLE_W-1:0]        t0_ff;
   logic [SAMPLE_W-1:0]        d_ff;
   logic signed [PROD_W-1:0]   out_rnd;
   logic signed [SAMPLE_W-1:0] out_ff;
   logic [SAMPLE_W:0]          interp_sum;
   logic [SAMPLE_W-1:0]        tanh_mag;
   logic [SAMPLE_W-1:0]        tanh_val;

   // output register
   logic                rsp_tvalid_ff;
   logic [SAMPLE_W-1:0] rsp_tdata_ff;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // delay length clamped to 1..RING_DEPTH when written
   always_comb begin
      tap_len_in = TAP_W'(csr_data[LEN_W-1:0]);
      if (tap_len_in == '0) begin
         tap_len_in = TAP_W'(1);
      end else if (tap_len_in > TAP_W'(RING_DEPTH)) begin
         tap_len_in = TAP_W'(RING_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff   <= '0;
         coef_b_ff   <= '0;
         coef_d_ff   <= '0;
         offset_c_ff <= '0;
         tap_len_ff  <= TAP_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COEF_A:    coef_a_ff   <= signed'(csr_data);
            REG_COEF_B:    coef_b_ff   <= signed'(csr_data);
            REG_COEF_D:    coef_d_ff   <= signed'(csr_data);
            REG_OFFSET_C:  offset_c_ff <= signed'(csr_data);
            REG_DELAY_LEN: tap_len_ff  <= tap_len_in;
            default: ;
         endcase
      end
   end

   // microprogram: one control word per step
   always_comb begin
      uc = '{RD_NONE, MUL_NONE, ACC_HOLD, AUX_NONE, COND_ALWAYS, STEP_IDLE};
      case (pc_ff)
         // wait for a sample, preload offset, fetch the delayed tap
         STEP_IDLE:   uc = '{RD_YL,   MUL_NONE,   ACC_INIT,  AUX_NONE,   COND_REQ,
                             STEP_SQUARE};
         // square the delayed tap, fetch the newest entry
         STEP_SQUARE: uc = '{RD_Y1,   MUL_YL_YL,  ACC_HOLD,  AUX_NONE,   COND_ALWAYS,
                             STEP_MUL_A};
         STEP_MUL_A:  uc = '{RD_Y2,   MUL_A_Y1,   ACC_HOLD,  AUX_SQ,     COND_ALWAYS,
                             STEP_MUL_B};
         STEP_MUL_B:  uc = '{RD_NONE, MUL_B_Y2,   ACC_ADD,   AUX_NONE,   COND_ALWAYS,
                             STEP_MUL_D};
         STEP_MUL_D:  uc = '{RD_NONE, MUL_D_SQ,   ACC_ADD,   AUX_NONE,   COND_ALWAYS,
                             STEP_MUL_X};
         STEP_MUL_X:  uc = '{RD_NONE, MUL_X_K,    ACC_ADD,   AUX_NONE,   COND_ALWAYS,
                             STEP_SUM};
         // add the scaled input and saturate to 32 bits
         STEP_SUM:    uc = '{RD_NONE, MUL_NONE,   ACC_FINAL, AUX_NONE,   COND_ALWAYS,
                             STEP_SCALE};
         // output gain, table index from |v|
         STEP_SCALE:  uc = '{RD_NONE, MUL_ACC_K,  ACC_HOLD,  AUX_MAG,    COND_ALWAYS,
                             STEP_LOOKUP};
         // round the output, fetch both table neighbors
         STEP_LOOKUP: uc = '{RD_NONE, MUL_NONE,   ACC_HOLD,  AUX_TAB,    COND_ALWAYS,
                             STEP_INTERP};
         STEP_INTERP: uc = '{RD_NONE, MUL_D_FRAC, ACC_HOLD,  AUX_NONE,   COND_ALWAYS,
                             STEP_COMMIT};
         // write ring, hand result over once the output register is free
         STEP_COMMIT: uc = '{RD_NONE, MUL_NONE,   ACC_HOLD,  AUX_COMMIT, COND_RSP,
                             STEP_IDLE};
         default:     uc = '{RD_NONE, MUL_NONE,   ACC_HOLD,  AUX_NONE,   COND_ALWAYS,
                             STEP_IDLE};
      endcase
   end

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (uc.cond == COND_REQ);

   always_comb begin
      case (uc.cond)
         COND_REQ: go = req_tvalid;
         COND_RSP: go = out_free;
         default:  go = 1'b1;
      endcase
   end

   assign pc_in     = go ? uc.next_step : pc_ff;
   assign commit_go = go && (uc.aux == AUX_COMMIT);

   // ring addressing; entries beyond the fill count read as zero
   assign addr_yl = RING_AW'(TAP_W'(wp_ff) - tap_len_ff - TAP_W'(1));

   always_comb begin
      case (uc.rd)
         RD_YL:   rd_addr = addr_yl;
         RD_Y2:   rd_addr = wp_ff - RING_AW'(1);
         default: rd_addr = wp_ff;
      endcase
   end

   assign rd_addr_ok = fill_ff[RING_AW] ||
                       ((rd_addr != '0) && (FILL_W'(rd_addr) <= fill_ff));
   assign rd_val     = rd_ok_ff ? signed'(mem_q_ff) : '0;

   assign wp_in   = wp_ff + RING_AW'(1);
   assign fill_in = fill_ff[RING_AW] ? fill_ff : fill_ff + FILL_W'(1);

   always_ff @(posedge clock) begin
      mem_q_ff <= ring_mem[rd_addr];
      if (commit_go) begin
         ring_mem[wp_in] <= tanh_val;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mul)
         MUL_YL_YL: begin
            mul_a = MUL_A_W'(rd_val);
            mul_b = MUL_B_W'(rd_val);
         end
         MUL_A_Y1: begin
            mul_a = MUL_A_W'(coef_a_ff);
            mul_b = MUL_B_W'(rd_val);
         end
         MUL_B_Y2: begin
            mul_a = MUL_A_W'(coef_b_ff);
            mul_b = MUL_B_W'(rd_val);
         end
         MUL_D_SQ: begin
            mul_a = MUL_A_W'(coef_d_ff);
            mul_b = MUL_B_W'(sq_ff);
         end
         MUL_X_K: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = INV_MAXAMP_Q16;
         end
         MUL_ACC_K: begin
            mul_a = accs_ff;
            mul_b = HALF_MAXAMP_Q16;
         end
         MUL_D_FRAC: begin
            mul_a = MUL_A_W'(d_ff);
            mul_b = MUL_B_W'(frac_ff);
         end
         default: ;
      endcase
   end

   // accumulator, tanh index and interpolation arithmetic
   assign acc_sum = acc_ff + ACC_W'(prod_ff >>> 4);
   assign mag     = accs_ff[ACCS_W-1] ? ACCS_W'(-accs_ff) : ACCS_W'(accs_ff);

   assign idx0 = {1'b0, idx_ff};
   assign idx1 = idx0 + (TANH_W + 1)'(1);
   assign t0   = TANH_TABLE[idx0];
   assign t1   = TANH_TABLE[idx1];

   assign out_rnd = (prod_ff + OUT_RND) >>> (ACC_FRAC + 2);

   assign interp_sum = (SAMPLE_W + 1)'(t0_ff) +
                       (SAMPLE_W + 1)'(prod_ff[INTERP_W +: SAMPLE_W]);
   assign tanh_mag   = (big_ff || (interp_sum > (SAMPLE_W + 1)'(TANH_MAX))) ?
                       TANH_MAX : interp_sum[SAMPLE_W-1:0];
   assign tanh_val   = neg_ff ? SAMPLE_W'(-tanh_mag) : tanh_mag;

   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_addr_ok;
      if (req_tvalid && req_tready) begin
         x_ff <= signed'(req_tdata);
      end
      if (uc.mul != MUL_NONE) begin
         prod_ff <= mul_a * mul_b;
      end
      if (go) begin
         case (uc.acc)
            ACC_INIT: acc_ff <= -(ACC_W'(offset_c_ff) <<< (ACC_FRAC - COEF_FRAC));
            ACC_ADD:  acc_ff <= acc_ff + ACC_W'(prod_ff);
            ACC_FINAL: begin
               if (acc_sum > ACC_POS_LIM) begin
                  accs_ff <= ACC_POS_LIM[ACCS_W-1:0];
               end else if (acc_sum < ACC_NEG_LIM) begin
                  accs_ff <= ACC_NEG_LIM[ACCS_W-1:0];
               end else begin
                  accs_ff <= acc_sum[ACCS_W-1:0];
               end
            end
            default: ;
         endcase
         case (uc.aux)
            // square floored to Q.15
            AUX_SQ: sq_ff <= prod_ff[15 +: SQ_W];
            AUX_MAG: begin
               neg_ff  <= accs_ff[ACCS_W-1];
               big_ff  <= |mag[ACCS_W-1:ACC_FRAC+2];
               idx_ff  <= mag[ACC_FRAC+1 -: TANH_W];
               frac_ff <= mag[ACC_FRAC+1-TANH_W -: INTERP_W];
            end
            AUX_TAB: begin
               t0_ff <= t0;
               d_ff  <= (t1 > t0) ? t1 - t0 : '0;
               if (accs_ff > ACC_TWO) begin
                  out_ff <= HALF_MAXAMP_Q14;
               end else if (accs_ff < ACC_MTWO) begin
                  out_ff <= -HALF_MAXAMP_Q14;
               end else begin
                  out_ff <= out_rnd[SAMPLE_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // control state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_IDLE;
         wp_ff         <= '0;
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (commit_go) begin
            wp_ff         <= wp_in;
            fill_ff       <= fill_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_tdata_ff <= out_ff;
      end
   end

   // checks
   `NFF_ASSERT_IMPL(a_fill_tracks_wp, clock, reset, !fill_ff[RING_AW],
                    wp_ff == fill_ff[RING_AW-1:0], "write pointer and fill count disagree")
   `NFF_ASSERT_IMPL(a_fill_bound, clock, reset, fill_ff[RING_AW],
                    fill_ff[RING_AW-1:0] == '0, "fill count beyond ring depth")
   `NFF_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready,
                    pc_ff == STEP_SQUARE, "accepted sample did not start the program")
   `NFF_ASSERT_IMPL(a_rsp_from_commit, clock, reset, $rose(rsp_tvalid_ff),
                    $past(pc_ff) == STEP_COMMIT, "result raised outside the commit step")
   `NFF_ASSERT_NEXT(a_wp_advances, clock, reset, commit_go,
                    wp_ff == $past(wp_ff) + 1'b1, "write pointer did not advance on commit")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the nonlinear feedback filter with a bit-exact scoreboard
module testbench;
   import nff_pkg::*;

   // fixed point constants of the filter datapath
   localparam longint IN_SCALE_Q16  = 33867;       // 1/1.935125 in Q0.16
   localparam longint OUT_SCALE_Q16 = 63410;       // 0.9675625 in Q0.16
   localparam longint CLIP_Q14      = 15853;       // 0.9675625 in Q2.14
   localparam longint LIMIT_Q27     = 64'sd1 << 28; // 2.0 in the Q.27 accumulator
   localparam longint TANH_SAT_Q27  = 64'sd1 << 29; // 4.0, tanh table end
   localparam longint ACC_MAX       = 64'sd2147483647;
   localparam longint ACC_MIN       = -64'sd2147483648;
   localparam int     MAX_REPORTS   = 10;

   // tracks filter state and holds the output samples still due
   class filter_scoreboard;
      int                  history [RING_DEPTH];
      int unsigned         newest;
      int                  gain_a, gain_b, gain_d, offset;
      int unsigned         tap_len;
      int                  tanh_lut [0:TANH_TABLE_SIZE];
      logic [SAMPLE_W-1:0] pending_outputs [$];
      int                  errors;
      int                  reported;

      function new();
         bit [63:0] one, y16, e, term, t;
         one = 64'd1 << 32;
         // tanh(4*i/size) = (e^2x - 1)/(e^2x + 1), e^y by an integer series
         for (int i = 0; i <= TANH_TABLE_SIZE; i++) begin
            y16  = (64'(8 * i) << 16) / 64'(TANH_TABLE_SIZE);
            e    = one;
            term = one;
            for (int k = 1; k < 100 && term != 0; k++) begin
               term = ((term * y16) >> 16) / 64'(k);
               e    = e + term;
            end
            t = ((e - one) * 64'd32768 + (e + one) / 64'd2) / (e + one);
            if (t > 64'd32767) t = 64'd32767;
            tanh_lut[i] = int'(t);
         end
         foreach (history[i]) history[i] = 0;
         newest   = 0;
         gain_a   = 0;
         gain_b   = 0;
         gain_d   = 0;
         offset   = 0;
         tap_len  = 1;
         errors   = 0;
         reported = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
         case (idx)
            REG_COEF_A:    gain_a = signed'(data);
            REG_COEF_B:    gain_b = signed'(data);
            REG_COEF_D:    gain_d = signed'(data);
            REG_OFFSET_C:  offset = signed'(data);
            REG_DELAY_LEN: tap_len = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // one filter step: output sample is queued, tanh of the sum enters the ring
      function void note_sample(logic [SAMPLE_W-1:0] din);
         longint              x, y1, y2, yl, sq, acc, mag, p, d, frac, r;
         int unsigned         len, idx;
         logic [SAMPLE_W-1:0] dout;
         x   = longint'(signed'(din));
         len = tap_len;
         if (len < 1) len = 1;
         if (len > RING_DEPTH) len = RING_DEPTH;
         y1  = history[newest];
         y2  = history[(newest + RING_DEPTH - 1) % RING_DEPTH];
         yl  = history[(newest + 2 * RING_DEPTH - len - 1) % RING_DEPTH];
         sq  = (yl * yl) >>> 15;
         acc = longint'(gain_a) * y1 + longint'(gain_b) * y2 + longint'(gain_d) * sq
             + ((x * IN_SCALE_Q16) >>> 4) - longint'(offset) * 32768;
         if (acc > ACC_MAX) acc = ACC_MAX;
         if (acc < ACC_MIN) acc = ACC_MIN;

         // output clip only when strictly beyond +-2
         if (acc > LIMIT_Q27) dout = 16'(CLIP_Q14);
         else if (acc < -LIMIT_Q27) dout = 16'(-CLIP_Q14);
         else dout = 16'((acc * OUT_SCALE_Q16 + LIMIT_Q27) >>> 29);

         // interpolated tanh on the magnitude, sign restored afterwards
         mag = (acc < 0) ? -acc : acc;
         if (mag >= TANH_SAT_Q27) begin
            r = 32767;
         end else begin
            p    = mag * TANH_TABLE_SIZE;
            idx  = int'(p >> 29);
            frac = (p & (TANH_SAT_Q27 - 1)) >> 13;
            d    = (tanh_lut[idx+1] > tanh_lut[idx]) ? tanh_lut[idx+1] - tanh_lut[idx] : 0;
            r    = tanh_lut[idx] + ((d * frac) >> 16);
            if (r > 32767) r = 32767;
         end
         newest = (newest + 1) % RING_DEPTH;
         history[newest] = int'((acc < 0) ? -r : r);
         pending_outputs.push_back(dout);
      endfunction

      function void check_sample(logic [SAMPLE_W-1:0] dout);
         logic [SAMPLE_W-1:0] want;
         if (pending_outputs.size() == 0) begin
            errors++;
            if (reported < MAX_REPORTS)
               $display("unexpected output sample %0d at %0t", $signed(dout), $realtime);
            reported++;
         end else begin
            want = pending_outputs.pop_front();
            if (want !== dout) begin
               errors++;
               if (reported < MAX_REPORTS)
                  $display("sample_out mismatch: expected %0d got %0d at %0t",
                           $signed(want), $signed(dout), $realtime);
               reported++;
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata;   // [15:0] sample_in
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [SAMPLE_W-1:0]  rsp_tdata;   // [15:0] sample_out
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SAMPLE_W-1:0]  csr_data;

   // no idling on either side while set
   bit steady;

   filter_scoreboard sb = new();

   nonlinear_feedback_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // all transactions are observed at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata);
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver stalls; a stall may cover any step of the block's work
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 15)
               hold = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 40);
         end
      end
   end

   // valid stays high across back-to-back samples, lowered only for a gap
   task automatic send_sample(input logic [SAMPLE_W-1:0] x);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and wait until every output sample has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending_outputs.size() != 0);
   endtask

   // the caller lowers csr_valid after its last write
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // full register set, written only with the datapath quiet; the ring write of the
   // last sample lands with its result, before its output transaction
   task automatic set_filter(input int a, input int b, input int d, input int c,
                             input int len_word);
      drain();
      repeat (16) @(negedge clock);
      csr_write(REG_COEF_A, 16'(a));
      csr_write(REG_COEF_B, 16'(b));
      csr_write(REG_COEF_D, 16'(d));
      csr_write(REG_OFFSET_C, 16'(c));
      // unused indexes must leave every register alone
      if ($urandom_range(0, 2) == 0)
         csr_write(CSR_IDX_W'($urandom_range(int'(REG_DELAY_LEN) + 1, (1 << CSR_IDX_W) - 1)),
                   16'($urandom));
      csr_write(REG_DELAY_LEN, 16'(len_word));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // gains: mostly a stable range, plus full scale, the extremes and zero
   function automatic int pick_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return int'($urandom_range(0, 6143)) - 3072;
      if (r < 70) return int'($urandom_range(0, 65535)) - 32768;
      if (r < 80) return 32767;
      if (r < 90) return -32768;
      return 0;
   endfunction

   function automatic int pick_delay_word();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 25) len = $urandom_range(1, 16);
      else if (r < 45) len = $urandom_range(1, RING_DEPTH);
      else if (r < 60) len = RING_DEPTH;
      else if (r < 70) len = 0;                  // treated as one
      else if (r < 80) len = $urandom_range(RING_DEPTH + 1, (1 << LEN_W) - 1);
      else if (r < 90) len = (1 << LEN_W) - 1;   // clamped to the ring depth
      else len = 1;
      // bits above the delay field are don't care
      return ($urandom_range(0, 31) << LEN_W) | len;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom);
      if (r < 85) return 16'(int'($urandom_range(0, 512)) - 256);
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   initial begin
      logic [SAMPLE_W-1:0] boundary_samples [7] =
         '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa};
      reset      = 1'b1;
      steady     = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: zero gains, output is about half the input
      foreach (boundary_samples[i]) send_sample(boundary_samples[i]);

      // offset of exactly -2: a zero input lands on the clip threshold itself
      set_filter(0, 0, 0, -8192, 1);
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'hffff);

      // mirrored threshold, zero delay length
      set_filter(0, 0, 0, 8192, 0);
      send_sample(16'h0000);
      send_sample(16'hffff);
      send_sample(16'h0001);

      // everything at full scale: accumulator saturates high, tanh saturates
      set_filter(32767, 32767, 32767, -32768, (1 << LEN_W) - 1);
      repeat (3) send_sample(16'h7fff);

      // and the negative side, delay at the ring depth
      set_filter(-32768, -32768, -32768, 32767, RING_DEPTH);
      repeat (3) send_sample(16'h8000);

      // random phases, each with its own register settings
      for (int phase = 0; phase < 8; phase++) begin
         set_filter(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_delay_word());
         steady = (phase == 2 || phase == 5);
         for (int n = 0; n < 200; n++) begin
            // one full pause mid-stream with samples still in flight
            if (phase == 3 && n == 100) drain();
            send_sample(pick_sample());
         end
         steady = 1'b0;
      end

      drain();
      repeat (30) @(negedge clock);
      if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> nonlinear_feedback_filter.f
+incdir+rtl
rtl/nff_pkg.sv
rtl/nonlinear_feedback_filter.sv
tb/testbench.sv
